// File: hdl/ssv_pkg.sv
// ----------------------------------------------------------------------------
// ssv_pkg: storage slot validator shared definitions
// Types and constants shared by the front and back ends, and the CRC-32 byte fold used by the back end.
// ----------------------------------------------------------------------------
package ssv_pkg;

  localparam int MAX_SLOT_BYTES = 256;
  localparam int POS_W          = $clog2(MAX_SLOT_BYTES + 1);
  localparam int LEN_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam int HDR_CRC_BYTES  = 12;
  localparam int BODY_START     = 16;
  localparam int MIN_SLOT       = 17;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC  = 3'd0,
    CFG_COMMIT = 3'd1,
    CFG_TYPE   = 3'd2,
    CFG_SCHEMA = 3'd3,
    CFG_MAXLEN = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_VALID        = 4'd0,
    ST_NOT_COMMIT   = 4'd1,
    ST_BAD_MAGIC    = 4'd2,
    ST_BAD_TYPE     = 4'd3,
    ST_BAD_SCHEMA   = 4'd4,
    ST_BAD_LENGTH   = 4'd5,
    ST_BAD_CRC      = 4'd6,
    ST_BAD_RESERVED = 4'd7,
    ST_TOO_SHORT    = 4'd8
  } status_t;

  // which header field a byte lands in
  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_MAGIC,
    CAP_TYPE,
    CAP_SCHEMA,
    CAP_LEN_LO,
    CAP_LEN_HI,
    CAP_CRC
  } cap_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             fold;
    cap_t             cap;
  } item_t;

  typedef struct packed {
    logic [31:0]      magic_word;
    logic [7:0]       commit_valid_value;
    logic [7:0]       req_type;
    logic [7:0]       req_schema;
    logic [LEN_W-1:0] max_payload_length;
  } cfg_t;

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: hdl/ssv_front.sv
// ----------------------------------------------------------------------------
// ssv_front: byte intake and classification
// Tracks the byte position in the slot and tags each byte with its header
// field and whether it is covered by the CRC.
// ----------------------------------------------------------------------------
module ssv_front import ssv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        push,
  output item_t       push_item,
  input  logic        q_full
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  cap_t             cap;

  assign in_stall = q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    cap = CAP_NONE;
    if (!last_byte) begin
      if (pos < POS_W'(4))                    cap = CAP_MAGIC;
      else if (pos == POS_W'(4))              cap = CAP_TYPE;
      else if (pos == POS_W'(5))              cap = CAP_SCHEMA;
      else if (pos == POS_W'(6))              cap = CAP_LEN_LO;
      else if (pos == POS_W'(7))              cap = CAP_LEN_HI;
      else if (pos >= POS_W'(HDR_CRC_BYTES) && pos < POS_W'(BODY_START))
                                              cap = CAP_CRC;
    end
  end

  always_comb begin
    push_item.data = data_byte;
    push_item.last = last_byte;
    push_item.pos  = pos;
    push_item.fold = !last_byte &&
                     (pos < POS_W'(HDR_CRC_BYTES) || pos >= POS_W'(BODY_START));
    push_item.cap  = cap;
  end

  always_comb begin
    pos_next = pos;
    if (push) begin
      if (last_byte)                         pos_next = '0;
      else if (pos < POS_W'(MAX_SLOT_BYTES)) pos_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else     pos <= pos_next;
  end

`ifndef SYNTHESIS
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    push && last_byte |=> pos == '0)
    else $error("position not cleared after commit byte");
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_SLOT_BYTES))
    else $error("position beyond saturation");
`endif

endmodule

// File: hdl/ssv_queue.sv
// ----------------------------------------------------------------------------
// ssv_queue: short FIFO between front and back ends
// Decouples byte intake from the result output stall.
// ----------------------------------------------------------------------------
module ssv_queue import ssv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

// File: hdl/ssv_back.sv
// ----------------------------------------------------------------------------
// ssv_back: CRC fold, header capture and status evaluation
// Consumes classified bytes and registers one result per commit byte.
// ----------------------------------------------------------------------------
module ssv_back import ssv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             head_valid,
  input  item_t            head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       status,
  output logic [LEN_W-1:0] payload_length,
  output logic [31:0]      computed_crc
);

  logic [31:0]      crc_reg;
  logic [31:0]      hdr_magic;
  logic [7:0]       hdr_type;
  logic [7:0]       hdr_schema;
  logic [LEN_W-1:0] hdr_len;
  logic [31:0]      stored_crc;
  logic             rsv_nonzero;

  logic [31:0]      crc_final;
  logic [LEN_W:0]   pos_ext;
  logic [LEN_W:0]   size;
  logic [LEN_W:0]   rsv_start;
  logic [LEN_W:0]   len_need;
  logic             len_bad;
  status_t          st;
  logic [4:0]       lane_sh;

  assign pop       = head_valid && (!head.last || !out_valid || !out_stall);
  assign crc_final = crc_reg ^ CRC_ONES;
  assign pos_ext   = (LEN_W+1)'(head.pos);
  assign size      = pos_ext + (LEN_W+1)'(1);
  assign rsv_start = (LEN_W+1)'(BODY_START) + {1'b0, hdr_len};
  assign len_need  = (LEN_W+1)'(MIN_SLOT) + {1'b0, hdr_len};
  assign lane_sh   = {head.pos[1:0], 3'b000};

  assign len_bad = hdr_len > cfg.max_payload_length ||
                   head.pos >= POS_W'(MAX_SLOT_BYTES) ||
                   len_need > size;

  always_comb begin
    if (size < (LEN_W+1)'(MIN_SLOT))            st = ST_TOO_SHORT;
    else if (head.data != cfg.commit_valid_value) st = ST_NOT_COMMIT;
    else if (hdr_magic != cfg.magic_word)       st = ST_BAD_MAGIC;
    else if (hdr_type != cfg.req_type)          st = ST_BAD_TYPE;
    else if (hdr_schema != cfg.req_schema)      st = ST_BAD_SCHEMA;
    else if (len_bad)                           st = ST_BAD_LENGTH;
    else if (stored_crc != crc_final)           st = ST_BAD_CRC;
    else if (rsv_nonzero)                       st = ST_BAD_RESERVED;
    else                                        st = ST_VALID;
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg     <= CRC_ONES;
      hdr_magic   <= '0;
      hdr_type    <= '0;
      hdr_schema  <= '0;
      hdr_len     <= '0;
      stored_crc  <= '0;
      rsv_nonzero <= 1'b0;
    end else if (pop) begin
      if (head.last) begin
        crc_reg     <= CRC_ONES;
        hdr_magic   <= '0;
        hdr_type    <= '0;
        hdr_schema  <= '0;
        hdr_len     <= '0;
        stored_crc  <= '0;
        rsv_nonzero <= 1'b0;
      end else begin
        if (head.fold) crc_reg <= crc_fold_byte(crc_reg, head.data);
        case (head.cap)
          CAP_MAGIC:  hdr_magic[lane_sh +: 8]  <= head.data;
          CAP_TYPE:   hdr_type                 <= head.data;
          CAP_SCHEMA: hdr_schema               <= head.data;
          CAP_LEN_LO: hdr_len[7:0]             <= head.data;
          CAP_LEN_HI: hdr_len[15:8]            <= head.data;
          CAP_CRC:    stored_crc[lane_sh +: 8] <= head.data;
          default:    ;
        endcase
        if (pos_ext >= rsv_start && head.data != 8'h00) rsv_nonzero <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      status         <= st;
      payload_length <= hdr_len;
      computed_crc   <= crc_final;
    end
  end

`ifndef SYNTHESIS
  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    pop && head.last |=> crc_reg == CRC_ONES && !rsv_nonzero)
    else $error("slot state not restarted after commit byte");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(pop && head.last))
    else $error("pending result overwritten");
`endif

endmodule

// File: hdl/storage_slot_validator_core.sv
// ----------------------------------------------------------------------------
// storage_slot_validator_core: record slot header and CRC-32 check
// Streams a slot byte by byte and reports one status per commit byte.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte, last_byte  | sink
//  out     | out_valid, out_stall, status,             | source
//          | payload_length, computed_crc              |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | sink
//
//  One byte per cycle sustained while in_stall is low; the CRC folds a full byte at once.
//  A result passes through the queue and then the result register after its commit byte is accepted.
//  rst is synchronous; config registers reset to zero, no clearing pass.
//  in_stall rises only when the two-entry queue is full, which happens
//  while out_stall holds a pending result and more bytes keep arriving.
// ----------------------------------------------------------------------------
module storage_slot_validator_core import ssv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [3:0]            status,
  output logic [LEN_W-1:0]      payload_length,
  output logic [31:0]           computed_crc,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  item_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAGIC:  cfg.magic_word         <= cfg_data;
        CFG_COMMIT: cfg.commit_valid_value <= cfg_data[7:0];
        CFG_TYPE:   cfg.req_type           <= cfg_data[7:0];
        CFG_SCHEMA: cfg.req_schema         <= cfg_data[7:0];
        CFG_MAXLEN: cfg.max_payload_length <= cfg_data[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  ssv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  ssv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ssv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_length (payload_length),
    .computed_crc   (computed_crc)
  );

endmodule

// File: test/tb_storage_slot_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_storage_slot_validator_core: slot validator self-checking testbench
// Streams record slots (well-formed, corrupted one field at a time, short,
// overlong and random noise) through several register settings. A CRC-32
// header checker predicts each verdict, and the results are compared field by
// field. The byte stream idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
import ssv_pkg::*;

typedef struct packed {
  status_t          status;
  logic [LEN_W-1:0] plen;
  logic [31:0]      crc;
} verdict_t;

// Predicts one verdict per commit byte and matches it against the block.
class slot_checker;
  localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
  localparam int HDR_COVERED   = 12;
  localparam int BODY_OFFSET   = 16;
  localparam int SHORTEST_SLOT = 17;
  localparam int MAX_REPORTS   = 30;

  logic [31:0]      magic_cfg;
  logic [7:0]       commit_cfg;
  logic [7:0]       type_cfg;
  logic [7:0]       schema_cfg;
  logic [LEN_W-1:0] maxlen_cfg;

  int               pos;
  logic [31:0]      crc_run;
  logic [31:0]      hdr_magic;
  logic [7:0]       hdr_type;
  logic [7:0]       hdr_schema;
  logic [LEN_W-1:0] hdr_len;
  logic [31:0]      hdr_crc;
  bit               resv_dirty;

  verdict_t         verdict_q[$];
  int               n_errors;
  int               n_checked;
  int               status_count[9];

  function new();
    magic_cfg  = '0;
    commit_cfg = '0;
    type_cfg   = '0;
    schema_cfg = '0;
    maxlen_cfg = '0;
    n_errors   = 0;
    n_checked  = 0;
    foreach (status_count[i]) status_count[i] = 0;
    restart();
  endfunction

  // bit-serial form of the reflected CRC-32 update
  static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ REFLECTED_POLY;
    end
    return r;
  endfunction

  function void restart();
    pos        = 0;
    crc_run    = '1;
    hdr_magic  = '0;
    hdr_type   = '0;
    hdr_schema = '0;
    hdr_len    = '0;
    hdr_crc    = '0;
    resv_dirty = 1'b0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [31:0] v);
    case (idx)
      CFG_MAGIC:  magic_cfg  = v;
      CFG_COMMIT: commit_cfg = v[7:0];
      CFG_TYPE:   type_cfg   = v[7:0];
      CFG_SCHEMA: schema_cfg = v[7:0];
      CFG_MAXLEN: maxlen_cfg = v[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    verdict_t    v;
    logic [31:0] fin;
    int          size;
    bit          overlong;
    if (!last) begin
      if (pos < 4) hdr_magic[pos*8 +: 8] = b;
      else if (pos == 4) hdr_type = b;
      else if (pos == 5) hdr_schema = b;
      else if (pos == 6) hdr_len[7:0] = b;
      else if (pos == 7) hdr_len[15:8] = b;
      else if (pos >= HDR_COVERED && pos < BODY_OFFSET)
        hdr_crc[(pos - HDR_COVERED)*8 +: 8] = b;
      if (pos < HDR_COVERED || pos >= BODY_OFFSET) crc_run = crc_step(crc_run, b);
      if (pos >= BODY_OFFSET + int'(hdr_len) && b != 8'h00) resv_dirty = 1'b1;
      if (pos < MAX_SLOT_BYTES) pos++;
      return;
    end
    fin      = crc_run ^ 32'hFFFF_FFFF;
    size     = pos + 1;
    overlong = pos >= MAX_SLOT_BYTES;
    if (size < SHORTEST_SLOT) v.status = ST_TOO_SHORT;
    else if (b != commit_cfg) v.status = ST_NOT_COMMIT;
    else if (hdr_magic != magic_cfg) v.status = ST_BAD_MAGIC;
    else if (hdr_type != type_cfg) v.status = ST_BAD_TYPE;
    else if (hdr_schema != schema_cfg) v.status = ST_BAD_SCHEMA;
    else if (hdr_len > maxlen_cfg || overlong || int'(hdr_len) + SHORTEST_SLOT > size)
      v.status = ST_BAD_LENGTH;
    else if (hdr_crc != fin) v.status = ST_BAD_CRC;
    else if (resv_dirty) v.status = ST_BAD_RESERVED;
    else v.status = ST_VALID;
    v.plen = hdr_len;
    v.crc  = fin;
    status_count[int'(v.status)]++;
    verdict_q.push_back(v);
    restart();
  endfunction

  task report(string what, logic [31:0] want, logic [31:0] got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("ERROR at %0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  task check_result(logic [3:0] st, logic [LEN_W-1:0] len, logic [31:0] crc);
    verdict_t v;
    n_checked++;
    if (verdict_q.size() == 0) begin
      report("result with nothing outstanding, status", 32'h0, 32'(st));
      return;
    end
    v = verdict_q.pop_front();
    if (st !== v.status) report("status", 32'(v.status), 32'(st));
    if (len !== v.plen) report("payload_length", 32'(v.plen), 32'(len));
    if (crc !== v.crc) report("computed_crc", v.crc, crc);
  endtask
endclass

module tb_storage_slot_validator_core;

  localparam int ITEM_TARGET     = 1950;
  localparam int SLOTS_PER_PHASE = 12;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum int {
    SK_GOOD,
    SK_NOT_COMMIT,
    SK_BAD_MAGIC,
    SK_BAD_TYPE,
    SK_BAD_SCHEMA,
    SK_LEN_OVER_MAX,
    SK_LEN_OVER_SIZE,
    SK_BAD_CRC,
    SK_BAD_RESERVED,
    SK_TOO_SHORT,
    SK_NOISE,
    SK_OVERLONG
  } slot_kind_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            data_byte;
  logic                  last_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [3:0]            status;
  logic [LEN_W-1:0]      payload_length;
  logic [31:0]           computed_crc;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_checker chk;
  cfg_t        cur_cfg;
  bit          calm;
  int          bytes_sent;
  int          slots_sent;
  int          n_settings;
  int          cycle_count;

  storage_slot_validator_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_length (payload_length),
    .computed_crc   (computed_crc),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, chk.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic int pick_size();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 75) return int'($urandom_range(17, 40));
    if (r < 95) return int'($urandom_range(41, 100));
    return int'($urandom_range(150, 256));
  endfunction

  function automatic slot_kind_t random_kind();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 2) return SK_OVERLONG;
    if (r < 40) return SK_GOOD;
    return slot_kind_t'($urandom_range(int'(SK_NOT_COMMIT), int'(SK_NOISE)));
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.magic_word         = $urandom();
    c.commit_valid_value = 8'($urandom_range(0, 255));
    c.req_type           = 8'($urandom_range(0, 255));
    c.req_schema         = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0: c.max_payload_length = '0;
      1: c.max_payload_length = 16'($urandom_range(1, 24));
      2: c.max_payload_length = 16'($urandom_range(25, 260));
      3: c.max_payload_length = 16'hFFFF;
      default: c.max_payload_length = 16'($urandom());
    endcase
    return c;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    chk.set_reg(idx, v);
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_MAGIC, c.magic_word);
    write_reg(CFG_COMMIT, {24'h0, c.commit_valid_value});
    write_reg(CFG_TYPE, {24'h0, c.req_type});
    write_reg(CFG_SCHEMA, {24'h0, c.req_schema});
    write_reg(CFG_MAXLEN, {16'h0, c.max_payload_length});
    cfg_valid <= 1'b0;
    cur_cfg = c;
    n_settings++;
  endtask

  // hold off the byte stream until every verdict has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (in_stall);
    chk.note_byte(b, last);
    bytes_sent++;
  endtask

  // size 0 means pick one that suits the kind
  task automatic send_slot(input slot_kind_t kind, input int size_req);
    logic [7:0]  body[$];
    logic [31:0] sum;
    int          n;
    int          lim;
    int          len_v;
    int          idx;
    n = size_req;
    if (n == 0) begin
      case (kind)
        SK_TOO_SHORT: n = int'($urandom_range(1, 16));
        SK_OVERLONG:  n = int'($urandom_range(257, 300));
        SK_NOISE:     n = int'($urandom_range(1, 48));
        default:      n = pick_size();
      endcase
    end
    if (kind == SK_BAD_RESERVED && n < 18) n = 18;
    for (int k = 0; k < n; k++) body.push_back(8'($urandom_range(0, 255)));

    if (kind != SK_NOISE && kind != SK_TOO_SHORT) begin
      lim = (kind == SK_BAD_RESERVED) ? n - 18 : n - 17;
      if (lim > int'(cur_cfg.max_payload_length)) lim = int'(cur_cfg.max_payload_length);
      len_v = ($urandom_range(0, 3) == 0) ? lim : int'($urandom_range(0, lim));
      if (kind == SK_LEN_OVER_MAX && cur_cfg.max_payload_length != 16'hFFFF) begin
        len_v = int'(cur_cfg.max_payload_length) + 1 + int'($urandom_range(0, 3));
        if (len_v > 16'hFFFF) len_v = 16'hFFFF;
      end else if (kind == SK_LEN_OVER_MAX || kind == SK_LEN_OVER_SIZE) begin
        len_v = n - 16 + int'($urandom_range(0, 20));
      end
      for (int k = 0; k < 4; k++) body[k] = cur_cfg.magic_word[k*8 +: 8];
      body[4] = cur_cfg.req_type;
      body[5] = cur_cfg.req_schema;
      body[6] = len_v[7:0];
      body[7] = len_v[15:8];
      for (int k = 16 + len_v; k < n - 1; k++) body[k] = 8'h00;
      if (kind == SK_BAD_RESERVED)
        body[$urandom_range(16 + len_v, n - 2)] = 8'($urandom_range(1, 255));
      body[n-1] = cur_cfg.commit_valid_value;
      sum = '1;
      for (int k = 0; k < n - 1; k++)
        if (k < 12 || k >= 16) sum = chk.crc_step(sum, body[k]);
      sum = ~sum;
      for (int k = 0; k < 4; k++) body[12 + k] = sum[k*8 +: 8];

      // for the field-corruption kinds, break one byte of the slot
      case (kind)
        SK_NOT_COMMIT: body[n-1] = body[n-1] ^ 8'($urandom_range(1, 255));
        SK_BAD_MAGIC: begin
          idx = int'($urandom_range(0, 3));
          body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        SK_BAD_TYPE:   body[4] = body[4] ^ (8'h01 << $urandom_range(0, 7));
        SK_BAD_SCHEMA: body[5] = body[5] ^ (8'h01 << $urandom_range(0, 7));
        SK_BAD_CRC: begin
          idx = int'($urandom_range(8, n - 2));
          body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        default: ;
      endcase
    end

    for (int k = 0; k < n; k++) send_byte(body[k], k == n - 1);
    slots_sent++;
  endtask

  // result side: random stall before each transaction
  initial begin
    int gap;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      chk.check_result(status, payload_length, computed_crc);
    end
  end

  initial begin
    cfg_t  c;
    int    in_phase;
    string tally;
    chk         = new();
    calm        = 1'b0;
    bytes_sent  = 0;
    slots_sent  = 0;
    n_settings  = 0;
    cycle_count = 0;
    cur_cfg     = '0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAGIC;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: zero config, boundaries of slot size, one slot per failure
    program_regs('0);
    send_slot(SK_TOO_SHORT, 1);
    send_slot(SK_TOO_SHORT, 16);
    send_slot(SK_GOOD, 17);
    for (int k = int'(SK_NOT_COMMIT); k <= int'(SK_BAD_RESERVED); k++)
      send_slot(slot_kind_t'(k), 20);
    send_slot(SK_GOOD, 256);
    send_slot(SK_OVERLONG, 257);
    send_slot(SK_NOISE, 17);

    // all registers at their top values
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    c.magic_word         = 32'hFFFF_FFFF;
    c.commit_valid_value = 8'hFF;
    c.req_type           = 8'hFF;
    c.req_schema         = 8'hFF;
    c.max_payload_length = 16'hFFFF;
    program_regs(c);

    in_phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (in_phase == SLOTS_PER_PHASE) begin
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        program_regs(random_cfg());
        in_phase = 0;
      end
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) drain_results();
      send_slot(random_kind(), 0);
      in_phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    tally = "";
    foreach (chk.status_count[i]) tally = {tally, $sformatf(" %0d", chk.status_count[i])};
    $display("%0d slots, %0d bytes over %0d register settings; %0d verdicts checked",
             slots_sent, bytes_sent, n_settings, chk.n_checked);
    $display("verdicts per status code 0..8:%s; %0d mismatches", tally, chk.n_errors);
    if (chk.n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
